### rtl/cmi_pkg.sv
package cmi_pkg;

	// Field widths
	localparam int SAMPLE_W = 24;
	localparam int SCALE_W  = 32;
	localparam int COUNT_W  = 4;
	localparam int CHAN_W   = 8;
	localparam int WORD_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int DATA_W   = 64;
	localparam int INDEX_W  = 3;

	// Register indexes on the configuration channel
	localparam logic [INDEX_W-1:0] REG_RANGE_MIN   = 3'd0;
	localparam logic [INDEX_W-1:0] REG_RANGE_SCALE = 3'd1;
	localparam logic [INDEX_W-1:0] REG_STOP_COUNT  = 3'd2;
	localparam logic [INDEX_W-1:0] REG_STOP_PAIR0  = 3'd3;

	// Reset values
	localparam logic [SCALE_W-1:0] RANGE_SCALE_RST = 32'h0001_0000;

	// Mapping registers shared by the front pipeline
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] range_min;
		logic        [SCALE_W-1:0]  range_scale;
	} cmi_cfg_t;

	// Selection result handed from the front pipeline to the blend stages
	typedef struct packed {
		logic              valid;
		logic              zero;
		logic [FRAC_W-1:0] t;
	} cmi_sel_t;

endpackage

### rtl/colormap_interpolator.sv
// Colormap interpolator: maps a signed 24-bit sample to an RGBA8888 color by
// linear blending between up to MAX_STOPS evenly spaced color stops.
// Input: a request is taken on each rising edge with start high and busy low.
//   busy is always low, so one sample can enter on every clock.
// Output: done pulses for one cycle with red, green, blue and alpha valid.
//   The receiver cannot hold results off; each request gives one result.
// Throughput: one sample per cycle, set by the five-stage pipeline
//   (offset, range multiply, stop select, channel multiply, add).
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
//   Index 0 range_min, 1 range_scale, 2 stop_count, 3..6 stop pairs (low word
//   is the even stop); index 7 is ignored. Write only while no request is in
//   flight.
// Reset: arst_n clears the pipeline valid bits and restores the register
//   defaults (range_min 0, range_scale 1.0 in Q16.16, no stops, all black).
module colormap_interpolator import cmi_pkg::*; #(
	parameter int MAX_STOPS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       done,
	output logic [CHAN_W-1:0]          red,
	output logic [CHAN_W-1:0]          green,
	output logic [CHAN_W-1:0]          blue,
	output logic [CHAN_W-1:0]          alpha,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [INDEX_W-1:0]         cfg_index,
	input  logic [DATA_W-1:0]          cfg_data
);

	localparam int CNT_W = $clog2(MAX_STOPS + 1);
	localparam int IDX_W = $clog2(MAX_STOPS);

	cmi_cfg_t          cfg;
	logic [CNT_W-1:0]  count;
	logic [WORD_W-1:0] stops [MAX_STOPS];
	cmi_sel_t          sel;
	logic [IDX_W-1:0]  lo_idx;
	logic [IDX_W-1:0]  hi_idx;

	// Pipeline never stalls
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	cmi_regs #(
		.MAX_STOPS (MAX_STOPS),
		.CNT_W     (CNT_W)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.count     (count),
		.stops     (stops)
	);

	cmi_front #(
		.MAX_STOPS (MAX_STOPS),
		.CNT_W     (CNT_W),
		.IDX_W     (IDX_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.sample   (sample),
		.cfg      (cfg),
		.count    (count),
		.sel      (sel),
		.lo_idx   (lo_idx),
		.hi_idx   (hi_idx)
	);

	cmi_blend #(
		.MAX_STOPS (MAX_STOPS),
		.IDX_W     (IDX_W)
	) u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.sel    (sel),
		.lo_idx (lo_idx),
		.hi_idx (hi_idx),
		.stops  (stops),
		.done   (done),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.alpha  (alpha)
	);

endmodule

### rtl/cmi_regs.sv
module cmi_regs import cmi_pkg::*; #(
	parameter int MAX_STOPS = 8,
	parameter int CNT_W     = $clog2(MAX_STOPS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0]   cfg_data,
	output cmi_cfg_t            cfg,
	output logic [CNT_W-1:0]    count,
	output logic [WORD_W-1:0]   stops [MAX_STOPS]
);

	logic signed [SAMPLE_W-1:0] range_min_q;
	logic [SCALE_W-1:0]         range_scale_q;
	logic [COUNT_W-1:0]         stop_count_q;
	logic [WORD_W-1:0]          stops_q [MAX_STOPS];

	// Take register writes; indexes past the stop pairs are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q   <= '0;
			range_scale_q <= RANGE_SCALE_RST;
			stop_count_q  <= '0;
			for (int i = 0; i < MAX_STOPS; i++) begin
				stops_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_RANGE_MIN) begin
				range_min_q <= cfg_data[SAMPLE_W-1:0];
			end
			if (cfg_index == REG_RANGE_SCALE) begin
				range_scale_q <= cfg_data[SCALE_W-1:0];
			end
			if (cfg_index == REG_STOP_COUNT) begin
				stop_count_q <= cfg_data[COUNT_W-1:0];
			end
			for (int i = 0; i < MAX_STOPS; i++) begin
				if (cfg_index == REG_STOP_PAIR0 + INDEX_W'(i >> 1)) begin
					stops_q[i] <= (i % 2 == 1) ? cfg_data[DATA_W-1:WORD_W]
						: cfg_data[WORD_W-1:0];
				end
			end
		end
	end

	// Clamp the stop count to the stops actually held
	always_comb begin
		if (stop_count_q > COUNT_W'(MAX_STOPS)) begin
			count = CNT_W'(MAX_STOPS);
		end else begin
			count = CNT_W'(stop_count_q);
		end
	end

	assign cfg.range_min   = range_min_q;
	assign cfg.range_scale = range_scale_q;
	assign stops           = stops_q;

endmodule

### rtl/cmi_front.sv
module cmi_front import cmi_pkg::*; #(
	parameter int MAX_STOPS = 8,
	parameter int CNT_W     = $clog2(MAX_STOPS + 1),
	parameter int IDX_W     = $clog2(MAX_STOPS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  cmi_cfg_t                   cfg,
	input  logic [CNT_W-1:0]           count,
	output cmi_sel_t                   sel,
	output logic [IDX_W-1:0]           lo_idx,
	output logic [IDX_W-1:0]           hi_idx
);

	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + SCALE_W + 1;
	localparam int P_W    = FRAC_W + CNT_W;

	logic                     valid_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic                     valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s3;
	logic                     zero_s3;
	logic [FRAC_W-1:0]        t_s3;
	logic [IDX_W-1:0]         lo_s3;
	logic [IDX_W-1:0]         hi_s3;

	logic                     positive;
	logic                     past_end;
	logic [FRAC_W-1:0]        frac;
	logic [CNT_W-1:0]         last;
	logic [P_W-1:0]           pos;
	logic                     zero_d;
	logic [FRAC_W-1:0]        t_d;
	logic [IDX_W-1:0]         lo_d;
	logic [IDX_W-1:0]         hi_d;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Offset from the low end of the range
	always_ff @(posedge clk) begin
		diff_s1 <= DIFF_W'(sample) - DIFF_W'(cfg.range_min);
	end

	// Scale to Q16.16
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(diff_s1) * $signed({1'b0, cfg.range_scale});
	end

	// Classify the fraction and pick the stop pair
	always_comb begin
		positive = !prod_s2[PROD_W-1] && (prod_s2 != '0);
		past_end = |prod_s2[PROD_W-2:2*FRAC_W];
		frac     = prod_s2[2*FRAC_W-1:FRAC_W];
		last     = count - CNT_W'(1);
		pos      = P_W'(frac) * P_W'(last);
		zero_d   = 1'b0;
		t_d      = '0;
		lo_d     = '0;
		hi_d     = '0;
		if (count == '0) begin
			zero_d = 1'b1;
		end else if (count == CNT_W'(1) || !positive) begin
			lo_d = '0;
			hi_d = '0;
		end else if (past_end) begin
			lo_d = IDX_W'(last);
			hi_d = IDX_W'(last);
		end else if (frac != '0) begin
			lo_d = pos[FRAC_W +: IDX_W];
			hi_d = pos[FRAC_W +: IDX_W] + IDX_W'(1);
			t_d  = pos[FRAC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		zero_s3 <= zero_d;
		t_s3    <= t_d;
		lo_s3   <= lo_d;
		hi_s3   <= hi_d;
	end

	assign sel.valid = valid_s3;
	assign sel.zero  = zero_s3;
	assign sel.t     = t_s3;
	assign lo_idx    = lo_s3;
	assign hi_idx    = hi_s3;

endmodule

### rtl/cmi_blend.sv
module cmi_blend import cmi_pkg::*; #(
	parameter int MAX_STOPS = 8,
	parameter int IDX_W     = $clog2(MAX_STOPS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmi_sel_t          sel,
	input  logic [IDX_W-1:0]  lo_idx,
	input  logic [IDX_W-1:0]  hi_idx,
	input  logic [WORD_W-1:0] stops [MAX_STOPS],
	output logic              done,
	output logic [CHAN_W-1:0] red,
	output logic [CHAN_W-1:0] green,
	output logic [CHAN_W-1:0] blue,
	output logic [CHAN_W-1:0] alpha
);

	localparam int NCH    = WORD_W / CHAN_W;
	localparam int MUL_W  = CHAN_W + FRAC_W + 2;

	logic [WORD_W-1:0]        c1;
	logic [WORD_W-1:0]        c2;
	logic signed [MUL_W-1:0]  mul_d [NCH];

	logic                     valid_s4;
	logic                     zero_s4;
	logic [WORD_W-1:0]        c1_s4;
	logic signed [MUL_W-1:0]  mul_s4 [NCH];

	logic                     valid_s5;
	logic [WORD_W-1:0]        word_s5;
	logic [WORD_W-1:0]        word_d;

	// Fetch the stop pair and scale each channel step by t
	always_comb begin
		c1 = stops[lo_idx];
		c2 = stops[hi_idx];
		for (int k = 0; k < NCH; k++) begin
			mul_d[k] = MUL_W'($signed({1'b0, c2[k*CHAN_W +: CHAN_W]})
				- $signed({1'b0, c1[k*CHAN_W +: CHAN_W]}))
				* $signed({1'b0, sel.t});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= sel.valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		zero_s4 <= sel.zero;
		c1_s4   <= c1;
		for (int k = 0; k < NCH; k++) begin
			mul_s4[k] <= mul_d[k];
		end
	end

	// Add the floored step to the lower stop; only the low byte survives
	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			word_d[k*CHAN_W +: CHAN_W] = c1_s4[k*CHAN_W +: CHAN_W]
				+ mul_s4[k][FRAC_W +: CHAN_W];
		end
		if (zero_s4) begin
			word_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		word_s5 <= word_d;
	end

	assign done  = valid_s5;
	assign red   = word_s5[4*CHAN_W-1:3*CHAN_W];
	assign green = word_s5[3*CHAN_W-1:2*CHAN_W];
	assign blue  = word_s5[2*CHAN_W-1:CHAN_W];
	assign alpha = word_s5[CHAN_W-1:0];

endmodule

### tb/colormap_interpolator_tb.sv
module colormap_interpolator_tb;
	import cmi_pkg::*;

	localparam int MAX_STOPS   = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_LIMIT  = 10;

	// Index 7 has no register behind it; writes there must be dropped
	localparam logic [INDEX_W-1:0] REG_STOP_PAIR3 = REG_STOP_PAIR0 + 3'd3;
	localparam logic [INDEX_W-1:0] REG_SPARE      = 3'd7;

	// Fixed palette for the directed part, RGBA8888
	localparam logic [WORD_W-1:0] STOP0 = 32'h10E0_00FF;
	localparam logic [WORD_W-1:0] STOP1 = 32'hF020_8000;
	localparam logic [WORD_W-1:0] STOP2 = 32'h0000_FF80;
	localparam logic [WORD_W-1:0] STOP3 = 32'hFFFF_0040;
	localparam logic [WORD_W-1:0] STOP4 = 32'h8040_2010;
	localparam logic [WORD_W-1:0] STOP5 = 32'h0102_0304;
	localparam logic [WORD_W-1:0] STOP6 = 32'hFE7F_8001;
	localparam logic [WORD_W-1:0] STOP7 = 32'h55AA_CC33;

	typedef enum logic [1:0] {ROW_WRITE, ROW_MAPPED, ROW_PINNED} row_kind_e;

	typedef struct packed {
		row_kind_e                  kind;
		logic [INDEX_W-1:0]         idx;
		logic [DATA_W-1:0]          data;
		logic signed [SAMPLE_W-1:0] smp;
		logic [WORD_W-1:0]          color;
	} plan_row_t;

	typedef struct packed {
		logic              pinned;
		logic [WORD_W-1:0] color;
	} pin_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       done;
	logic [CHAN_W-1:0]          red;
	logic [CHAN_W-1:0]          green;
	logic [CHAN_W-1:0]          blue;
	logic [CHAN_W-1:0]          alpha;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [INDEX_W-1:0]         cfg_index;
	logic [DATA_W-1:0]          cfg_data;

	// Local copy of the mapping registers
	logic signed [SAMPLE_W-1:0] map_min   = '0;
	logic [SCALE_W-1:0]         map_scale = RANGE_SCALE_RST;
	logic [COUNT_W-1:0]         map_count = '0;
	logic [WORD_W-1:0]          map_stops [MAX_STOPS];

	logic [WORD_W-1:0] color_q [$];
	pin_t              pin_q [$];
	plan_row_t         plan [$];
	pin_t              slot;
	logic [WORD_W-1:0] want;
	int                pair_slot;

	bit quiet;
	int fails;
	int cycles;
	int n_accepted;
	int n_checked;
	int n_writes;

	colormap_interpolator #(
		.MAX_STOPS(MAX_STOPS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		foreach (map_stops[i]) map_stops[i] = '0;
	end

	// Blend one channel: lo + floor((hi - lo) * t / 2^16)
	function automatic logic [CHAN_W-1:0] blend_chan(logic [CHAN_W-1:0] c_lo,
			logic [CHAN_W-1:0] c_hi, int t);
		int step;
		int acc;
		step = int'(c_hi) - int'(c_lo);
		acc = int'(c_lo) + ((step * t) >>> 16);
		return acc[CHAN_W-1:0];
	endfunction

	// Expected color for one sample under the current registers
	function automatic logic [WORD_W-1:0] map_sample(logic signed [SAMPLE_W-1:0] value);
		int unsigned       used;
		longint            offset;
		longint            gain;
		longint            scaled;
		longint            frac;
		longint            pos;
		int                seg;
		int                t;
		logic [WORD_W-1:0] lo_w;
		logic [WORD_W-1:0] hi_w;
		logic [WORD_W-1:0] mixed;
		used = (map_count > MAX_STOPS) ? MAX_STOPS : map_count;
		if (used == 0)
			return '0;
		if (used == 1)
			return map_stops[0];
		offset = longint'(value);
		offset = offset - map_min;
		gain = longint'(map_scale);
		scaled = offset * gain;
		if (scaled <= 0)
			return map_stops[0];
		frac = scaled >>> FRAC_W;
		if (frac == 0)
			return map_stops[0];
		if (frac >= 65536)
			return map_stops[used - 1];
		pos = frac * longint'(used - 1);
		seg = int'((pos >>> FRAC_W) & 7);
		t = int'(pos & 65535);
		lo_w = map_stops[seg];
		hi_w = map_stops[seg + 1];
		for (int ch = 0; ch < 4; ch++)
			mixed[ch*CHAN_W +: CHAN_W] = blend_chan(lo_w[ch*CHAN_W +: CHAN_W],
				hi_w[ch*CHAN_W +: CHAN_W], t);
		return mixed;
	endfunction

	function automatic bit take_gap();
		return !quiet && ($urandom_range(0, 99) < 26);
	endfunction

	task automatic report(input string msg);
		fails++;
		if (fails <= SHOW_LIMIT)
			$display("%s", msg);
	endtask

	// Present one sample; hold start until the block takes it
	task automatic present_sample(input logic signed [SAMPLE_W-1:0] value,
			input logic pinned, input logic [WORD_W-1:0] color);
		pin_q.push_back('{pinned, color});
		while (take_gap()) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cfg_valid <= 1'b0;
		sample <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write one register over the configuration channel
	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
		while (take_gap()) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		n_writes++;
		@(negedge clk);
	endtask

	// Hold off until every request in flight has returned its color
	task automatic settle();
		while (color_q.size() != 0 || pin_q.size() != 0) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	function automatic void plan_write(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
		plan.push_back('{ROW_WRITE, idx, data, '0, '0});
	endfunction

	function automatic void plan_sample(logic signed [SAMPLE_W-1:0] smp);
		plan.push_back('{ROW_MAPPED, '0, '0, smp, '0});
	endfunction

	function automatic void plan_pinned(logic signed [SAMPLE_W-1:0] smp,
			logic [WORD_W-1:0] color);
		plan.push_back('{ROW_PINNED, '0, '0, smp, color});
	endfunction

	function automatic logic [WORD_W-1:0] rand_stop();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly samples inside the mapped span, some anywhere, some at the edges
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(
			logic signed [SAMPLE_W-1:0] base, int unsigned span);
		longint lv;
		int     r;
		r = $urandom_range(0, 99);
		lv = longint'(base);
		if (r < 75)
			lv = lv + longint'($urandom_range(0, span + span / 4)) - longint'(span / 8);
		else if (r < 90)
			lv = longint'($urandom);
		else begin
			case ($urandom_range(0, 3))
				0: lv = -8388608;
				1: lv = 8388607;
				2: lv = longint'(base);
				default: lv = lv + longint'(span);
			endcase
		end
		return lv[SAMPLE_W-1:0];
	endfunction

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d colors pending", cycles, color_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Track accepted requests and register writes, check each returned color
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				slot = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
				color_q.push_back(slot.pinned ? slot.color : map_sample(sample));
				n_accepted++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RANGE_MIN: map_min = cfg_data[SAMPLE_W-1:0];
					REG_RANGE_SCALE: map_scale = cfg_data[SCALE_W-1:0];
					REG_STOP_COUNT: map_count = cfg_data[COUNT_W-1:0];
					REG_SPARE: ;
					default: begin
						pair_slot = int'(cfg_index - REG_STOP_PAIR0) * 2;
						map_stops[pair_slot] = cfg_data[WORD_W-1:0];
						map_stops[pair_slot + 1] = cfg_data[DATA_W-1:WORD_W];
					end
				endcase
			end
			if (done) begin
				if (color_q.size() == 0) begin
					report($sformatf("color r=%02h g=%02h b=%02h a=%02h with no request pending",
						red, green, blue, alpha));
				end else begin
					want = color_q.pop_front();
					n_checked++;
					if ({red, green, blue, alpha} !== want)
						report($sformatf({"color mismatch: want r=%02h g=%02h b=%02h a=%02h,",
							" got r=%02h g=%02h b=%02h a=%02h"},
							want[31:24], want[23:16], want[15:8], want[7:0],
							red, green, blue, alpha));
				end
			end
		end
	end

	initial begin
		logic signed [SAMPLE_W-1:0] base;
		logic [SCALE_W-1:0]         scale;
		logic [COUNT_W-1:0]         cnt;
		logic [DATA_W-1:0]          junk;
		int unsigned                span;
		int                         n_items;

		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: registers at reset give black everywhere
		plan_pinned(24'sd0, '0);
		plan_pinned(-24'sd8388608, '0);
		plan_pinned(24'sd8388607, '0);
		plan_write(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
		plan_pinned(24'sd1234, '0);
		plan_write(REG_STOP_PAIR0, {STOP1, STOP0});
		plan_write(REG_STOP_PAIR0 + 3'd1, {STOP3, STOP2});
		plan_write(REG_STOP_PAIR0 + 3'd2, {STOP5, STOP4});
		plan_write(REG_STOP_PAIR3, {STOP7, STOP6});
		plan_pinned(-24'sd5, '0);
		// Single stop: same color for any sample
		plan_write(REG_STOP_COUNT, 64'd1);
		plan_pinned(24'sd8388607, STOP0);
		plan_pinned(-24'sd8388608, STOP0);
		// Full 24-bit span, all eight stops
		plan_write(REG_RANGE_MIN, 64'hABCD_0000_0080_0000);
		plan_write(REG_RANGE_SCALE, 64'd257);
		plan_write(REG_STOP_COUNT, 64'd8);
		plan_pinned(-24'sd8388608, STOP0);
		plan_pinned(24'sd8388607, STOP7);
		plan_sample(24'sd0);
		plan_sample(-24'sd1);
		plan_sample(24'sd4194304);
		// Count above the stop limit clamps to eight
		plan_write(REG_STOP_COUNT, 64'd15);
		plan_pinned(24'sd8388607, STOP7);
		plan_sample(24'sd100);
		plan_sample(-24'sd3000000);
		// Zero scale pins everything to the first stop
		plan_write(REG_RANGE_SCALE, 64'd0);
		plan_pinned(24'sd0, STOP0);
		plan_pinned(24'sd8388607, STOP0);
		// Maximum scale, two stops, samples at, below and just above the range start
		plan_write(REG_RANGE_MIN, 64'h0000_0000_007F_FFFF);
		plan_write(REG_RANGE_SCALE, 64'hFFFF_FFFF);
		plan_write(REG_STOP_COUNT, 64'd2);
		plan_pinned(24'sd8388607, STOP0);
		plan_pinned(-24'sd8388608, STOP0);
		plan_write(REG_RANGE_MIN, 64'd0);
		plan_sample(24'sd1);
		plan_pinned(24'sd2, STOP1);
		// Three stops with unit scale, exact hit on the middle stop
		plan_write(REG_RANGE_SCALE, 64'h0001_0000);
		plan_write(REG_STOP_COUNT, 64'd3);
		plan_pinned(24'sd32768, STOP1);
		plan_sample(24'sd32767);
		plan_sample(24'sd49152);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_WRITE: begin
					settle();
					write_reg(plan[i].idx, plan[i].data);
				end
				ROW_MAPPED: present_sample(plan[i].smp, 1'b0, '0);
				default: present_sample(plan[i].smp, 1'b1, plan[i].color);
			endcase
		end

		// Random phases, each under a fresh register setting
		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph == 3);
			settle();
			span = $urandom_range(2, 1 << $urandom_range(1, 24));
			base = SAMPLE_W'($urandom);
			if (ph == 1)
				base = -24'sd8388608;
			if (ph == 6)
				base = 24'sd8388607;
			case ($urandom_range(0, 9))
				0: scale = '0;
				1: scale = '1;
				default: scale = SCALE_W'((64'd1 << 32) / span);
			endcase
			case (ph)
				0, 3: cnt = 4'd8;
				1: cnt = 4'd2;
				2: cnt = COUNT_W'($urandom_range(3, 7));
				4: cnt = COUNT_W'($urandom_range(9, 15));
				5: cnt = 4'd1;
				6: cnt = 4'd0;
				default: cnt = COUNT_W'($urandom_range(0, 15));
			endcase
			junk = {$urandom, $urandom};
			write_reg(REG_RANGE_MIN, {junk[DATA_W-1:SAMPLE_W], base});
			junk = {$urandom, $urandom};
			write_reg(REG_RANGE_SCALE, {junk[DATA_W-1:SCALE_W], scale});
			for (int k = 0; k < 4; k++)
				write_reg(REG_STOP_PAIR0 + INDEX_W'(k), {rand_stop(), rand_stop()});
			junk = {$urandom, $urandom};
			write_reg(REG_STOP_COUNT, {junk[DATA_W-1:COUNT_W], cnt});
			if (ph == 5)
				write_reg(REG_SPARE, {$urandom, $urandom});
			n_items = (cnt < 2) ? 40 : 130;
			repeat (n_items)
				present_sample(pick_sample(base, span), 1'b0, '0);
		end

		// Drain the pipeline, then watch for stray results
		start <= 1'b0;
		cfg_valid <= 1'b0;
		while (color_q.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		if (color_q.size() != 0)
			report($sformatf("%0d colors never returned", color_q.size()));

		$display("run: %0d samples mapped (%0d directed rows), %0d colors checked",
			n_accepted, plan.size(), n_checked);
		$display("run: %0d register writes over 8 random settings, %0d failures",
			n_writes, fails);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
